// File: src/metp_pkg.sv
// ----------------------------------------------------------------------------
// metp_pkg: shared types and constants for the escape-time pixel engine
// Register codes, reset values, sequencer states and fixed-point helpers.
// ----------------------------------------------------------------------------
package metp_pkg;

	localparam int PIX_W      = 9;
	localparam int COORD_W    = 32;
	localparam int COUNT_W    = 16;
	localparam int GRAY_W     = 8;
	localparam int FRAC_BITS  = 27;
	localparam int OPND_W     = 33;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int SQ_W       = 64;
	localparam int SUM_W      = 44;
	localparam int ESC_BIT    = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam int DEF_IMAGE_WIDTH  = 512;
	localparam int DEF_IMAGE_HEIGHT = 512;

	localparam logic [COUNT_W-1:0] RST_ITER_LIMIT = 16'd255;
	localparam logic [COORD_W-1:0] RST_REAL_MIN   = 32'hF400_0000;
	localparam logic [COORD_W-1:0] RST_REAL_MAX   = 32'h0800_0000;
	localparam logic [COORD_W-1:0] RST_IMAG_MIN   = 32'hF800_0000;
	localparam logic [COORD_W-1:0] RST_IMAG_MAX   = 32'h0800_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ITER_LIMIT = 3'd0,
		REG_REAL_MIN   = 3'd1,
		REG_REAL_MAX   = 3'd2,
		REG_IMAG_MIN   = 3'd3,
		REG_IMAG_MAX   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_R,
		ST_MAP_I,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_UPDATE,
		ST_DONE
	} seq_state_t;

	function automatic int log2_floor(input int v);
		int s;
		int t;
		s = 0;
		t = v;
		while (t > 1) begin
			t = t >> 1;
			s = s + 1;
		end
		return s;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - SUM_W'(1);
		if (v > hi)
			return {1'b0, {(COORD_W-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

// File: src/metp_mul.sv
// ----------------------------------------------------------------------------
// metp_mul: shared signed multiplier
// One 33 x 33 signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module metp_mul (
	input  logic                                 clk,
	input  logic signed [metp_pkg::OPND_W-1:0]   a,
	input  logic signed [metp_pkg::OPND_W-1:0]   b,
	output logic signed [metp_pkg::PROD_W-1:0]   prod
);

	logic signed [metp_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// File: src/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time engine for one pixel per word
// Maps a pixel to a Q4.27 point c and iterates z = z*z + c until |z|^2
// reaches 4 or the iteration limit is hit; returns the count and gray level.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time; s_axis_tready is low while it iterates.
// A pixel passes through the mapping states MAP_R and MAP_I, then through
// MUL_RR, MUL_II, MUL_RI and UPDATE for each iteration and once more for the
// pass that finds the escape or the limit; DONE then loads the output register
// once it is free or being taken, and the next pixel is accepted in IDLE.
// One shared 33 x 33 multiplier forms x*span, y*span, zr*zr, zi*zi and zr*zi
// in turn.
// The finished word waits in an output register, so the next pixel can
// start while it is not yet taken.
module mandelbrot_escape_time_pixel #(
	parameter int IMAGE_WIDTH  = metp_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = metp_pkg::DEF_IMAGE_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [metp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [metp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// pixel_x [8:0], pixel_y [17:9], zero [23:18]
	input  logic [metp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// escape_count [15:0], gray_level [23:16]
	output logic [metp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int SHIFT_X = metp_pkg::log2_floor(IMAGE_WIDTH);
	localparam int SHIFT_Y = metp_pkg::log2_floor(IMAGE_HEIGHT);
	localparam int CW = metp_pkg::COORD_W;
	localparam int SW = metp_pkg::SUM_W;
	localparam int QW = metp_pkg::SQ_W;
	localparam int OW = metp_pkg::OPND_W;

	metp_pkg::seq_state_t state_q, state_d;

	logic [metp_pkg::COUNT_W-1:0] limit_q;
	logic [CW-1:0]                real_min_q, real_max_q, imag_min_q, imag_max_q;

	logic [metp_pkg::PIX_W-1:0]   px_q, py_q;
	logic signed [OW-1:0]         span_r_q, span_i_q;
	logic signed [CW-1:0]         cr_q, ci_q, zr_q, zi_q;
	logic signed [QW-1:0]         rr_q, diff_q;
	logic                         esc_q;
	logic [metp_pkg::COUNT_W-1:0] count_q;

	logic                         out_valid_q;
	logic [metp_pkg::COUNT_W-1:0] out_count_q;

	logic signed [OW-1:0]                 mul_a, mul_b;
	logic signed [metp_pkg::PROD_W-1:0]   prod;
	logic signed [QW-1:0]                 prod64;
	logic [QW-1:0]                        esc_sum;
	logic signed [SW-1:0]                 map_sum;
	logic signed [SW-1:0]                 zr_sum, zi_sum;
	logic                                 done;
	logic                                 out_load;

	metp_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign prod64  = prod[QW-1:0];
	assign esc_sum = unsigned'(rr_q) + unsigned'(prod64);
	assign done    = (count_q >= limit_q) || esc_q;

	always_comb begin
		map_sum = SW'(signed'(cr_q));
		if (state_q == metp_pkg::ST_MAP_I)
			map_sum = SW'(signed'(real_min_q)) + SW'(prod >>> SHIFT_X);
		else if (state_q == metp_pkg::ST_MUL_RR)
			map_sum = SW'(signed'(imag_min_q)) + SW'(prod >>> SHIFT_Y);
	end

	assign zr_sum = SW'(diff_q >>> metp_pkg::FRAC_BITS) + SW'(cr_q);
	assign zi_sum = SW'(prod64 >>> (metp_pkg::FRAC_BITS - 1)) + SW'(ci_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			metp_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = metp_pkg::ST_MAP_R;
			metp_pkg::ST_MAP_R:  state_d = metp_pkg::ST_MAP_I;
			metp_pkg::ST_MAP_I:  state_d = metp_pkg::ST_MUL_RR;
			metp_pkg::ST_MUL_RR: state_d = metp_pkg::ST_MUL_II;
			metp_pkg::ST_MUL_II: state_d = metp_pkg::ST_MUL_RI;
			metp_pkg::ST_MUL_RI: state_d = metp_pkg::ST_UPDATE;
			metp_pkg::ST_UPDATE: state_d = done ? metp_pkg::ST_DONE : metp_pkg::ST_MUL_RR;
			metp_pkg::ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = metp_pkg::ST_IDLE;
			default:             state_d = metp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mul_a         = OW'(zr_q);
		mul_b         = OW'(zi_q);
		case (state_q)
			metp_pkg::ST_IDLE: s_axis_tready = 1'b1;
			metp_pkg::ST_MAP_R: begin
				mul_a = signed'(OW'(px_q));
				mul_b = span_r_q;
			end
			metp_pkg::ST_MAP_I: begin
				mul_a = signed'(OW'(py_q));
				mul_b = span_i_q;
			end
			metp_pkg::ST_MUL_RR: begin
				mul_a = OW'(zr_q);
				mul_b = OW'(zr_q);
			end
			metp_pkg::ST_MUL_II: begin
				mul_a = OW'(zi_q);
				mul_b = OW'(zi_q);
			end
			metp_pkg::ST_MUL_RI: begin
				mul_a = OW'(zr_q);
				mul_b = OW'(zi_q);
			end
			// rebuild y*span so the next pass reloads the same ci
			metp_pkg::ST_UPDATE: begin
				mul_a = signed'(OW'(py_q));
				mul_b = span_i_q;
			end
			metp_pkg::ST_DONE: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= metp_pkg::ST_IDLE;
			limit_q     <= metp_pkg::RST_ITER_LIMIT;
			real_min_q  <= metp_pkg::RST_REAL_MIN;
			real_max_q  <= metp_pkg::RST_REAL_MAX;
			imag_min_q  <= metp_pkg::RST_IMAG_MIN;
			imag_max_q  <= metp_pkg::RST_IMAG_MAX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					metp_pkg::REG_ITER_LIMIT: limit_q    <= cfg_data[metp_pkg::COUNT_W-1:0];
					metp_pkg::REG_REAL_MIN:   real_min_q <= cfg_data[CW-1:0];
					metp_pkg::REG_REAL_MAX:   real_max_q <= cfg_data[CW-1:0];
					metp_pkg::REG_IMAG_MIN:   imag_min_q <= cfg_data[CW-1:0];
					metp_pkg::REG_IMAG_MAX:   imag_max_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			metp_pkg::ST_IDLE: begin
				px_q     <= s_axis_tdata[metp_pkg::PIX_W-1:0];
				py_q     <= s_axis_tdata[2*metp_pkg::PIX_W-1:metp_pkg::PIX_W];
				span_r_q <= signed'({real_max_q[CW-1], real_max_q})
					- signed'({real_min_q[CW-1], real_min_q});
				span_i_q <= signed'({imag_max_q[CW-1], imag_max_q})
					- signed'({imag_min_q[CW-1], imag_min_q});
				zr_q     <= '0;
				zi_q     <= '0;
				count_q  <= '0;
			end
			metp_pkg::ST_MAP_I:  cr_q <= metp_pkg::sat32(map_sum);
			metp_pkg::ST_MUL_RR: ci_q <= metp_pkg::sat32(map_sum);
			metp_pkg::ST_MUL_II: rr_q <= prod64;
			metp_pkg::ST_MUL_RI: begin
				esc_q  <= esc_sum[QW-1:metp_pkg::ESC_BIT] != '0;
				diff_q <= rr_q - prod64;
			end
			metp_pkg::ST_UPDATE: begin
				if (!done) begin
					zr_q    <= metp_pkg::sat32(zr_sum);
					zi_q    <= metp_pkg::sat32(zi_sum);
					count_q <= count_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load)
			out_count_q <= count_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_count_q[metp_pkg::GRAY_W-1:0], out_count_q};

endmodule

// File: src/metp_checker.sv
// ----------------------------------------------------------------------------
// metp_checker: port-level checks for the escape-time pixel engine
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module metp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [metp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int GW = metp_pkg::GRAY_W;
	localparam int CWD = metp_pkg::COUNT_W;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_gray_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[CWD+GW-1:CWD] == m_axis_tdata[GW-1:0])
		else $error("gray level differs from low byte of escape count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while a pixel is iterating");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared right after an input word");

endmodule

bind mandelbrot_escape_time_pixel metp_checker u_metp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
